// File: rtl/core/pawu_pkg.sv
// shared types and constants of the pid step block with integral clamp
package pawu_pkg;

   // fixed field widths of the ports
   localparam int SAMPLE_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int LIMIT_W = 31;

   // digit-serial multiplier: the 32-bit coefficient goes in 4-bit digits
   localparam int MUL_B_W = 32;
   localparam int DIGIT_BITS = 4;
   localparam int NUM_DIGITS = MUL_B_W / DIGIT_BITS;
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEG_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_TIME = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_STEP_TIME = 3'd6;

   // register reset values
   localparam logic signed [MUL_B_W-1:0] RST_PROP_GAIN = 32'sd327680;
   localparam logic signed [MUL_B_W-1:0] RST_INTEG_GAIN = 32'sd6554;
   localparam logic signed [MUL_B_W-1:0] RST_DERIV_GAIN = 32'sd32768;
   localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 31'd131072;
   localparam logic [LIMIT_W-1:0] RST_OUT_LIMIT = 31'd131072;
   localparam logic [LIMIT_W-1:0] RST_STEP_TIME = 31'd1092;
   localparam logic [LIMIT_W-1:0] RST_INV_STEP_TIME = 31'd3932160;

   // item commands
   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic signed [MUL_B_W-1:0] prop_gain;
      logic signed [MUL_B_W-1:0] integ_gain;
      logic signed [MUL_B_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]        integ_limit;
      logic [LIMIT_W-1:0]        out_limit;
      logic [LIMIT_W-1:0]        step_time;
      logic [LIMIT_W-1:0]        inv_step_time;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
   } mul_stat_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_RUN,
      MUL_SAT,
      MUL_DONE
   } mul_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_S,
      ST_LIM_I,
      ST_MUL_I,
      ST_MUL_R,
      ST_MUL_D,
      ST_SUM,
      ST_OUT
   } ctrl_state_type;

endpackage

// File: rtl/core/pawu_csr.sv
// configuration registers of the pid step block
module pawu_csr
   import pawu_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   // limits are stored already cut down to the largest data value
   localparam logic [LIMIT_W-1:0] LIM_MAX = (DATA_WIDTH >= 32) ? {LIMIT_W{1'b1}} :
      LIMIT_W'((33'd1 << (DATA_WIDTH - 1)) - 33'd1);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   function automatic logic [LIMIT_W-1:0] lim_sat(input logic [LIMIT_W-1:0] v);
      return (v > LIM_MAX) ? LIM_MAX : v;
   endfunction

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PROP_GAIN:     cfg_in.prop_gain = csr_wdata;
            REG_INTEG_GAIN:    cfg_in.integ_gain = csr_wdata;
            REG_DERIV_GAIN:    cfg_in.deriv_gain = csr_wdata;
            REG_INTEG_LIMIT:   cfg_in.integ_limit = lim_sat(csr_wdata[LIMIT_W-1:0]);
            REG_OUT_LIMIT:     cfg_in.out_limit = lim_sat(csr_wdata[LIMIT_W-1:0]);
            REG_STEP_TIME:     cfg_in.step_time = csr_wdata[LIMIT_W-1:0];
            REG_INV_STEP_TIME: cfg_in.inv_step_time = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain <= RST_PROP_GAIN;
         cfg_ff.integ_gain <= RST_INTEG_GAIN;
         cfg_ff.deriv_gain <= RST_DERIV_GAIN;
         cfg_ff.integ_limit <= lim_sat(RST_INTEG_LIMIT);
         cfg_ff.out_limit <= lim_sat(RST_OUT_LIMIT);
         cfg_ff.step_time <= RST_STEP_TIME;
         cfg_ff.inv_step_time <= RST_INV_STEP_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/pawu_digit_mul.sv
// digit-serial signed multiplier with fixed-point scaling and saturation
module pawu_digit_mul
   import pawu_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH:0]   op_a,
   input  logic signed [MUL_B_W-1:0]    op_b,
   output mul_stat_type                 stat,
   output logic signed [DATA_WIDTH-1:0] result
);

   localparam int AW = DATA_WIDTH + 1;
   localparam int TW = AW + DIGIT_BITS + 1;
   localparam int FW = AW + MUL_B_W;
   localparam int OW = FW - FRAC_BITS - DATA_WIDTH + 1;
   localparam logic signed [DATA_WIDTH-1:0] DATA_HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] DATA_LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   mul_state_type                state_ff, state_in;
   logic signed [AW-1:0]         a_ff, a_in;
   logic [MUL_B_W-1:0]           b_ff, b_in;
   logic signed [AW-1:0]         acc_ff, acc_in;
   logic [MUL_B_W-1:0]           low_ff, low_in;
   logic [DIGIT_CNT_W-1:0]       cnt_ff, cnt_in;
   logic signed [DATA_WIDTH-1:0] res_ff, res_in;

   logic                         last_digit;
   logic signed [DIGIT_BITS:0]   digit;
   logic signed [TW-1:0]         part;
   logic signed [TW-1:0]         sum_t;
   logic [FW-1:0]                full;
   logic [OW-1:0]                over_bits;
   logic                         fits;

   // top digit carries the sign of the coefficient
   assign last_digit = (cnt_ff == DIGIT_CNT_W'(NUM_DIGITS - 1));
   assign digit = last_digit ? {b_ff[DIGIT_BITS-1], b_ff[DIGIT_BITS-1:0]}
                             : {1'b0, b_ff[DIGIT_BITS-1:0]};
   assign part = TW'(digit) * TW'(a_ff);
   assign sum_t = TW'(acc_ff) + part;

   // full product, then floor shift by the fraction and range check
   assign full = {acc_ff, low_ff};
   assign over_bits = full[FW-1:FRAC_BITS+DATA_WIDTH-1];
   assign fits = (&over_bits) | (~|over_bits);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MUL_IDLE: if (start) state_in = MUL_RUN;
         MUL_RUN:  if (last_digit) state_in = MUL_SAT;
         MUL_SAT:  state_in = MUL_DONE;
         MUL_DONE: state_in = MUL_IDLE;
      endcase
   end

   always_comb begin
      stat.idle = (state_ff == MUL_IDLE);
      stat.done = (state_ff == MUL_DONE);
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      low_in = low_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      unique case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               a_in = op_a;
               b_in = op_b;
               acc_in = '0;
               low_in = '0;
               cnt_in = '0;
            end
         end
         MUL_RUN: begin
            acc_in = sum_t[AW+DIGIT_BITS-1:DIGIT_BITS];
            low_in = {sum_t[DIGIT_BITS-1:0], low_ff[MUL_B_W-1:DIGIT_BITS]};
            b_in = b_ff >> DIGIT_BITS;
            cnt_in = cnt_ff + DIGIT_CNT_W'(1);
         end
         MUL_SAT: begin
            if (fits) begin
               res_in = full[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
            end else begin
               res_in = full[FW-1] ? DATA_LO : DATA_HI;
            end
         end
         MUL_DONE: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign result = res_ff;

`ifndef ASSERT_OFF
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == MUL_RUN) && (cnt_ff == '0))
      else $error("multiplier did not start its digit pass");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MUL_DONE) |=> (state_ff == MUL_IDLE))
      else $error("multiplier done lasted more than one cycle");
`endif

endmodule

// File: rtl/core/pid_anti_windup_step.sv
// top level of the pid step block with integral clamp
//
// one pid step per item in signed fixed point (DATA_WIDTH bits, FRAC_BITS
// fraction bits, Q16.16 by default). a step item goes from acceptance to
// the result register through five passes of the one shared multiplier,
// which issues, works the 32-bit coefficient in 4-bit digits, saturates and
// hands off, and through the integral clamp, the three-term sum and the
// output clamp; a clear item goes straight to the output step. no new item
// is taken until the current one is in the result register, but the next
// item is accepted while a finished result still waits on the result side.
// products are floored by the fraction bits and saturated to the data
// range; the integral and the output are clamped to the symmetric limits,
// which are cut down to the largest data value when written. configuration
// must be written only while idle; the block itself does not enforce it
module pid_anti_windup_step
   import pawu_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // input items
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic signed [SAMPLE_W-1:0] req_err_sample,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_control_out,
   // configuration writes
   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = DATA_WIDTH + 1;
   localparam int XW = DATA_WIDTH + 2;
   localparam int WW = (XW > SAMPLE_W) ? XW : SAMPLE_W;
   localparam logic signed [WW-1:0] DATA_HI_W =
      {{(WW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [WW-1:0] DATA_LO_W = ~DATA_HI_W;

   // control state
   ctrl_state_type               state_ff, state_in;
   logic                         issue_ff, issue_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] integ_ff, integ_in;
   logic signed [DATA_WIDTH-1:0] last_ff, last_in;

   // payload
   logic signed [SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic signed [DATA_WIDTH-1:0] e_ff, e_in;
   logic signed [DATA_WIDTH-1:0] p_ff, p_in;
   logic signed [DATA_WIDTH-1:0] i_ff, i_in;
   logic signed [DATA_WIDTH-1:0] rate_ff, rate_in;
   logic signed [DATA_WIDTH-1:0] d_ff, d_in;
   logic signed [XW-1:0]         wide_ff, wide_in;

   cfg_type                      cfg;
   mul_stat_type                 mul_stat;
   logic signed [DATA_WIDTH-1:0] mul_res;
   logic signed [AW-1:0]         op_a;
   logic signed [MUL_B_W-1:0]    op_b;
   logic                         accept;
   logic                         out_load;
   logic signed [WW-1:0]         err_w;
   logic signed [WW-1:0]         e_sat_w;
   logic signed [DATA_WIDTH-1:0] out_clamp;
   logic signed [WW-1:0]         out_w;

   // symmetric clamp; lim never exceeds the data range, so this covers saturation too
   function automatic logic signed [DATA_WIDTH-1:0] clamp_sym(
      input logic signed [XW-1:0] v,
      input logic [LIMIT_W-1:0]   lim
   );
      logic signed [WW-1:0] v_w;
      logic signed [WW-1:0] l_w;
      logic signed [WW-1:0] r_w;
      v_w = WW'(v);
      l_w = $signed(WW'(lim));
      if (v_w > l_w) begin
         r_w = l_w;
      end else if (v_w < -l_w) begin
         r_w = -l_w;
      end else begin
         r_w = v_w;
      end
      return r_w[DATA_WIDTH-1:0];
   endfunction

   pawu_csr #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   pawu_digit_mul #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (issue_ff),
      .op_a  (op_a),
      .op_b  (op_b),
      .stat  (mul_stat),
      .result(mul_res)
   );

   assign accept = req_valid && req_ready;

   // incoming error saturated to the data range
   assign err_w = WW'(req_err_sample);
   assign e_sat_w = (err_w > DATA_HI_W) ? DATA_HI_W :
                    (err_w < DATA_LO_W) ? DATA_LO_W : err_w;

   assign out_clamp = clamp_sym(wide_ff, cfg.out_limit);
   assign out_w = WW'(out_clamp);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == CMD_CLEAR) ? ST_OUT : ST_MUL_P;
            end
         end
         ST_MUL_P: if (mul_stat.done) state_in = ST_MUL_S;
         ST_MUL_S: if (mul_stat.done) state_in = ST_LIM_I;
         ST_LIM_I: state_in = ST_MUL_I;
         ST_MUL_I: if (mul_stat.done) state_in = ST_MUL_R;
         ST_MUL_R: if (mul_stat.done) state_in = ST_MUL_D;
         ST_MUL_D: if (mul_stat.done) state_in = ST_SUM;
         ST_SUM:   state_in = ST_OUT;
         ST_OUT:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      // one start pulse on entry to each multiply
      issue_in = (state_in != state_ff) &&
                 ((state_in == ST_MUL_P) || (state_in == ST_MUL_S) ||
                  (state_in == ST_MUL_I) || (state_in == ST_MUL_R) ||
                  (state_in == ST_MUL_D));
   end

   // state outputs: handshake and multiplier operands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_MUL_P: begin
            op_a = AW'(e_ff);
            op_b = cfg.prop_gain;
         end
         ST_MUL_S: begin
            op_a = AW'(e_ff);
            op_b = $signed({1'b0, cfg.step_time});
         end
         ST_MUL_I: begin
            op_a = AW'(integ_ff);
            op_b = cfg.integ_gain;
         end
         ST_MUL_R: begin
            // error difference needs one extra bit
            op_a = AW'(e_ff) - AW'(last_ff);
            op_b = $signed({1'b0, cfg.inv_step_time});
         end
         ST_MUL_D: begin
            op_a = AW'(rate_ff);
            op_b = cfg.deriv_gain;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      integ_in = integ_ff;
      last_in = last_ff;
      e_in = e_ff;
      p_in = p_ff;
      i_in = i_ff;
      rate_in = rate_ff;
      d_in = d_ff;
      wide_in = wide_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CLEAR) begin
                  integ_in = '0;
                  last_in = '0;
                  wide_in = '0;
               end else begin
                  e_in = e_sat_w[DATA_WIDTH-1:0];
               end
            end
         end
         ST_MUL_P: if (mul_stat.done) p_in = mul_res;
         ST_MUL_S: begin
            // raw integral sum, clamped in the next cycle
            if (mul_stat.done) wide_in = XW'(integ_ff) + XW'(mul_res);
         end
         ST_LIM_I: integ_in = clamp_sym(wide_ff, cfg.integ_limit);
         ST_MUL_I: if (mul_stat.done) i_in = mul_res;
         ST_MUL_R: begin
            if (mul_stat.done) begin
               rate_in = mul_res;
               last_in = e_ff;
            end
         end
         ST_MUL_D: if (mul_stat.done) d_in = mul_res;
         ST_SUM:   wide_in = XW'(p_ff) + XW'(i_ff) + XW'(d_ff);
         default: ;
      endcase
   end

   // result register, free again once its item is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = out_w[SAMPLE_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff <= '0;
         last_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff <= integ_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      e_ff <= e_in;
      p_ff <= p_in;
      i_ff <= i_in;
      rate_ff <= rate_in;
      d_ff <= d_in;
      wide_ff <= wide_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_control_out = rsp_data_ff;

`ifndef ASSERT_OFF
   a_issue_idle: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> mul_stat.idle)
      else $error("multiply issued while the multiplier is busy");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> mul_stat.idle)
      else $error("taking items while a multiply is still running");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result shown outside the output step");
`endif

endmodule

// File: verif/pid_step_checker.sv
// checker for the pid step block: mirrors the registers, predicts each result and compares
module pid_step_checker
   import pawu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_cmd,
   input  logic signed [SAMPLE_W-1:0] req_err_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_control_out,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [95:0] wide_type;

   localparam wide_type DATA_MAX = 96'sd2147483647;
   localparam wide_type DATA_MIN = -96'sd2147483648;

   typedef struct {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] err;
      logic signed [SAMPLE_W-1:0] control_out;
   } step_result_type;

   cfg_type                    regs;
   logic signed [SAMPLE_W-1:0] integral_q;
   logic signed [SAMPLE_W-1:0] prev_err_q;
   step_result_type            results_due[$];
   int                         errors = 0;
   int                         results_seen = 0;

   function automatic wide_type fit_data(input wide_type v);
      if (v > DATA_MAX) return DATA_MAX;
      if (v < DATA_MIN) return DATA_MIN;
      return v;
   endfunction

   // floored fixed-point product, saturated to the data range
   function automatic wide_type q_product(input wide_type a, input wide_type g);
      wide_type prod;
      prod = a * g;
      return fit_data(prod >>> FRAC_BITS);
   endfunction

   function automatic wide_type bound_to(input wide_type v, input wide_type lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pid_step_output(
      input logic cmd, input logic signed [SAMPLE_W-1:0] err);
      wide_type e, prev, acc, kp, ki, kd, st, inv, ilim, olim;
      wide_type p_term, i_term, rate, d_term, total;
      if (cmd == CMD_CLEAR) begin
         integral_q = '0;
         prev_err_q = '0;
         return '0;
      end
      e = err;
      prev = prev_err_q;
      acc = integral_q;
      kp = $signed(regs.prop_gain);
      ki = $signed(regs.integ_gain);
      kd = $signed(regs.deriv_gain);
      st = regs.step_time;
      inv = regs.inv_step_time;
      ilim = regs.integ_limit;
      olim = regs.out_limit;

      p_term = q_product(e, kp);
      acc = bound_to(fit_data(acc + q_product(e, st)), ilim);
      integral_q = acc[SAMPLE_W-1:0];
      i_term = q_product(acc, ki);
      rate = q_product(e - prev, inv);
      d_term = q_product(rate, kd);
      prev_err_q = err;
      total = bound_to(fit_data(p_term + i_term + d_term), olim);
      return total[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      step_result_type want;
      if (reset) begin
         regs.prop_gain = RST_PROP_GAIN;
         regs.integ_gain = RST_INTEG_GAIN;
         regs.deriv_gain = RST_DERIV_GAIN;
         regs.integ_limit = RST_INTEG_LIMIT;
         regs.out_limit = RST_OUT_LIMIT;
         regs.step_time = RST_STEP_TIME;
         regs.inv_step_time = RST_INV_STEP_TIME;
         integral_q = '0;
         prev_err_q = '0;
         results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] unexpected result item %0d: control_out %0d",
                           $realtime, results_seen, rsp_control_out);
            end else begin
               want = results_due.pop_front();
               if (rsp_control_out !== want.control_out) begin
                  errors++;
                  if (errors <= 10)
                     $display({"[%0t] item %0d (cmd %0b err %0d): ",
                               "control_out expected %0d got %0d"},
                              $realtime, results_seen, want.cmd, want.err,
                              want.control_out, rsp_control_out);
               end
            end
         end
         if (req_valid && req_ready) begin
            want.cmd = req_cmd;
            want.err = req_err_sample;
            want.control_out = pid_step_output(req_cmd, req_err_sample);
            results_due.insert(results_due.size(), want);
         end
         if (csr_we) begin
            case (csr_index)
               REG_PROP_GAIN: regs.prop_gain = csr_wdata;
               REG_INTEG_GAIN: regs.integ_gain = csr_wdata;
               REG_DERIV_GAIN: regs.deriv_gain = csr_wdata;
               REG_INTEG_LIMIT: regs.integ_limit = csr_wdata[LIMIT_W-1:0];
               REG_OUT_LIMIT: regs.out_limit = csr_wdata[LIMIT_W-1:0];
               REG_STEP_TIME: regs.step_time = csr_wdata[LIMIT_W-1:0];
               REG_INV_STEP_TIME: regs.inv_step_time = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= errors;
      pending <= results_due.size();
   end

endmodule

// File: verif/tb.sv
// testbench top for the pid step block: stimulus, register phases and the verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pawu_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int PHASES = 5;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int WATCHDOG_NS = 15_000_000;
   // index 7 has no register behind it
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 3'd7;
   localparam logic signed [SAMPLE_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] ERR_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] ERR_ONE = 32'sh0001_0000;

   typedef enum int {CFG_TYPICAL, CFG_WIDE, CFG_EXTREME} cfg_style_type;
   typedef enum int {RDY_OPEN, RDY_CHOPPY, RDY_SLOW} ready_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_cmd;
   logic signed [SAMPLE_W-1:0] req_err_sample;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_control_out;
   logic                       csr_we;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;
   int                         fail_count;
   int                         pending;

   // sender bookkeeping: items left in the current burst, valid currently held high
   int burst_left = 1;
   bit holding = 1'b0;
   // drifting error, mimics a loop settling toward its setpoint
   int walk_err = 0;

   pid_anti_windup_step DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_err_sample(req_err_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_control_out(rsp_control_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pid_step_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_err_sample(req_err_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_control_out(rsp_control_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // extreme values of a signed 32-bit field
   function automatic logic [31:0] corner32();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // extreme values of a 31-bit limit or time field, zero included
   function automatic logic [LIMIT_W-1:0] corner31();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 31'd1;
         2: return 31'h7FFF_FFFF;
         default: return 31'h0001_0000;
      endcase
   endfunction

   function automatic cfg_type pick_regs(input cfg_style_type style);
      cfg_type c;
      case (style)
         CFG_TYPICAL: begin
            // gains within +-10.0, limits up to 16.0, realistic sample periods
            c.prop_gain = $urandom_range(0, 20 * 65536) - 10 * 65536;
            c.integ_gain = $urandom_range(0, 20 * 65536) - 10 * 65536;
            c.deriv_gain = $urandom_range(0, 4 * 65536) - 2 * 65536;
            c.integ_limit = LIMIT_W'($urandom_range(0, 16 * 65536));
            c.out_limit = LIMIT_W'($urandom_range(0, 16 * 65536));
            c.step_time = LIMIT_W'($urandom_range(1, 65536));
            c.inv_step_time = LIMIT_W'($urandom_range(1, 1 << 22));
         end
         CFG_WIDE: begin
            c.prop_gain = $urandom;
            c.integ_gain = $urandom;
            c.deriv_gain = $urandom;
            c.integ_limit = LIMIT_W'($urandom);
            c.out_limit = LIMIT_W'($urandom);
            c.step_time = LIMIT_W'($urandom);
            c.inv_step_time = LIMIT_W'($urandom);
         end
         default: begin
            c.prop_gain = corner32();
            c.integ_gain = corner32();
            c.deriv_gain = corner32();
            c.integ_limit = corner31();
            c.out_limit = corner31();
            c.step_time = corner31();
            c.inv_step_time = corner31();
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_error();
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            walk_err = walk_err + int'($urandom_range(0, 16384)) - 8192;
            if (walk_err > 8 * 65536 || walk_err < -8 * 65536) walk_err = 0;
            return walk_err;
         end
         3, 4: return $urandom_range(0, 1 << 19) - (1 << 18);
         5, 6: return $urandom;
         7: return corner32();
         8: return int'($urandom_range(0, 32)) - 16;
         default: return {($urandom_range(0, 1) ? 2'b01 : 2'b10), 30'($urandom)};
      endcase
   endfunction

   // one item; at the end of a burst valid drops for a random gap
   task automatic send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] err);
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_err_sample <= err;
      holding = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         // mostly short gaps, sometimes long enough to land anywhere in a step
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            holding = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // sender holds off until every predicted result has come back
   task automatic wait_all_results();
      if (holding) begin
         req_valid <= 1'b0;
         holding = 1'b0;
      end
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // full register set, back to back; bit 31 of the 31-bit registers is random junk
   task automatic write_regs(input cfg_type c, input bit spare);
      csr_write(REG_PROP_GAIN, c.prop_gain);
      csr_write(REG_INTEG_GAIN, c.integ_gain);
      csr_write(REG_DERIV_GAIN, c.deriv_gain);
      csr_write(REG_INTEG_LIMIT, {1'($urandom), c.integ_limit});
      csr_write(REG_OUT_LIMIT, {1'($urandom), c.out_limit});
      csr_write(REG_STEP_TIME, {1'($urandom), c.step_time});
      csr_write(REG_INV_STEP_TIME, {1'($urandom), c.inv_step_time});
      if (spare) csr_write(REG_SPARE, $urandom);
      csr_we <= 1'b0;
   endtask

   // result side: runs of always-ready, choppy and mostly-stalled
   initial begin
      ready_mode_type mode;
      int run;
      rsp_ready <= 1'b0;
      mode = RDY_OPEN;
      run = 0;
      forever begin
         @(posedge clock);
         if (run == 0) begin
            mode = ready_mode_type'($urandom_range(0, 2));
            run = $urandom_range(10, 300);
         end
         run--;
         case (mode)
            RDY_OPEN: rsp_ready <= 1'b1;
            RDY_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 11) == 0);
         endcase
      end
   end

   // main stimulus
   initial begin
      req_valid <= 1'b0;
      req_cmd <= CMD_STEP;
      req_err_sample <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: zero, unit, extremes, integral driven into its clamp
      send_item(CMD_STEP, '0);
      send_item(CMD_STEP, ERR_ONE);
      send_item(CMD_STEP, ERR_MAX);
      send_item(CMD_STEP, ERR_MAX);
      send_item(CMD_STEP, ERR_MAX);
      send_item(CMD_STEP, ERR_MIN);
      send_item(CMD_STEP, -1);
      // clear with a nonzero sample, then a step from clean state
      send_item(CMD_CLEAR, ERR_MAX);
      send_item(CMD_STEP, -32'sh0002_0000);
      wait_all_results();
      repeat (2) @(posedge clock);

      // integral limit of zero and zero step times: only the p term is left
      write_regs('{prop_gain: ERR_ONE, integ_gain: ERR_ONE, deriv_gain: ERR_ONE,
                   integ_limit: '0, out_limit: 31'h7FFF_FFFF, step_time: '0,
                   inv_step_time: '0}, 1'b1);
      send_item(CMD_STEP, ERR_MAX);
      send_item(CMD_STEP, ERR_MIN);
      send_item(CMD_STEP, 32'sh0003_8000);
      wait_all_results();
      repeat (2) @(posedge clock);

      // output limit of zero holds the output at zero
      write_regs('{prop_gain: ERR_MAX, integ_gain: ERR_MIN, deriv_gain: ERR_MAX,
                   integ_limit: 31'h7FFF_FFFF, out_limit: '0, step_time: 31'h7FFF_FFFF,
                   inv_step_time: 31'h7FFF_FFFF}, 1'b0);
      send_item(CMD_STEP, ERR_MAX);
      send_item(CMD_STEP, ERR_MIN);
      wait_all_results();
      repeat (2) @(posedge clock);

      // every product and sum pushed past the data range
      write_regs('{prop_gain: ERR_MIN, integ_gain: ERR_MAX, deriv_gain: ERR_MIN,
                   integ_limit: 31'h7FFF_FFFF, out_limit: 31'h7FFF_FFFF,
                   step_time: 31'h7FFF_FFFF, inv_step_time: 31'h7FFF_FFFF}, 1'b0);
      send_item(CMD_STEP, ERR_MAX);
      send_item(CMD_STEP, ERR_MIN);
      send_item(CMD_STEP, ERR_MAX);
      send_item(CMD_CLEAR, ERR_MIN);
      send_item(CMD_STEP, ERR_MIN);

      // random phases, each under a fresh register set
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_all_results();
         repeat (2) @(posedge clock);
         write_regs(pick_regs(cfg_style_type'(ph % 3)), ph == PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // halfway through, let the block drain completely
            if (n == ITEMS_PER_PHASE / 2) wait_all_results();
            send_item(($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_STEP, pick_error());
         end
      end

      wait_all_results();
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #(WATCHDOG_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
